### rtl/imu_sfp_pkg.sv
`default_nettype none

package imu_sfp_pkg;

  localparam int unsigned MaxFrameBytes = 11;
  localparam int unsigned CounterBits   = 32;
  localparam int unsigned PosBits       = 4;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrBits  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntBits  = $clog2(QueueDepth + 1);

  localparam int unsigned LegacyLen = 5;
  localparam int unsigned Axis6Len  = 11;
  localparam int unsigned LegacyEff = (LegacyLen > MaxFrameBytes) ? MaxFrameBytes : LegacyLen;
  localparam int unsigned Axis6Eff  = (Axis6Len > MaxFrameBytes) ? MaxFrameBytes : Axis6Len;

  localparam logic [7:0] HdrByte   = 8'h5A;
  localparam logic [7:0] TypeGyro  = 8'hAA;
  localparam logic [7:0] TypeAngle = 8'hBB;
  localparam logic [7:0] TypeAccel = 8'hCC;
  localparam logic [7:0] TypeQuat  = 8'hDD;
  localparam logic [7:0] TypeReg   = 8'hEE;

  typedef enum logic [2:0] {
    KIND_GYRO  = 3'd0,
    KIND_ANGLE = 3'd1,
    KIND_ACCEL = 3'd2,
    KIND_QUAT  = 3'd3,
    KIND_REG   = 3'd4,
    KIND_NONE  = 3'd7
  } kind_e;

  typedef logic [CounterBits-1:0] count_t;

  typedef struct packed {
    kind_e        kind;
    logic         ok;
    logic [15:0]  v1;
    logic [15:0]  v2;
    logic [15:0]  v3;
    logic [15:0]  v4;
    count_t       byte_total;
  } frame_rec_t;

  typedef struct packed {
    kind_e        kind;
    logic         ok;
    logic [15:0]  v1;
    logic [15:0]  v2;
    logic [15:0]  v3;
    logic [15:0]  v4;
    count_t       kind_total;
    count_t       err_total;
    count_t       byte_total;
  } result_t;

  function automatic kind_e kind_of(input logic [7:0] t, input logic six_axis);
    kind_e k;
    k = KIND_NONE;
    if (t == TypeGyro) begin
      k = KIND_GYRO;
    end else if (t == TypeAngle) begin
      k = KIND_ANGLE;
    end else if (six_axis) begin
      if (t == TypeAccel) k = KIND_ACCEL;
      else if (t == TypeQuat) k = KIND_QUAT;
      else if (t == TypeReg) k = KIND_REG;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/imu_sfp_front.sv
`default_nettype none

module imu_sfp_front (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire                     cfg_wdata_i,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire  [7:0]              in_byte_i,
  input  wire                     q_full_i,
  output logic                    q_push_o,
  output imu_sfp_pkg::frame_rec_t q_rec_o
);
  import imu_sfp_pkg::*;

  logic               format_q;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [7:0]         sum_q, sum_d;
  kind_e              kind_q, kind_d;
  count_t             bytes_q, bytes_d;
  logic [7:0]         buf_q [MaxFrameBytes];

  logic [PosBits-1:0] last_pos;
  logic               at_last;
  logic               accept;
  kind_e              in_kind;
  logic               ok;

  function automatic logic [7:0] buf_at(input int unsigned i, input logic [7:0] b [MaxFrameBytes]);
    logic [7:0] r;
    r = '0;
    for (int unsigned j = 0; j < MaxFrameBytes; j++) begin
      if (j == i) r = b[j];
    end
    return r;
  endfunction

  assign last_pos   = format_q ? PosBits'(Axis6Eff - 1) : PosBits'(LegacyEff - 1);
  assign at_last    = (pos_q == last_pos);
  assign in_ready_o = !(at_last && q_full_i);
  assign accept     = in_valid_i && in_ready_o;
  assign in_kind    = kind_of(in_byte_i, format_q);
  assign ok         = (sum_q == in_byte_i);
  assign q_push_o   = accept && at_last && !cfg_we_i;

  always_comb begin
    q_rec_o            = '0;
    q_rec_o.kind       = kind_q;
    q_rec_o.ok         = ok;
    q_rec_o.byte_total = bytes_d;
    if (ok) begin
      q_rec_o.v1 = {buf_at(3, buf_q), buf_at(2, buf_q)};
      if (format_q) begin
        q_rec_o.v2 = {buf_at(5, buf_q), buf_at(4, buf_q)};
        q_rec_o.v3 = {buf_at(7, buf_q), buf_at(6, buf_q)};
        if (kind_q == KIND_QUAT) q_rec_o.v4 = {buf_at(9, buf_q), buf_at(8, buf_q)};
      end
    end
  end

  always_comb begin
    pos_d   = pos_q;
    sum_d   = sum_q;
    kind_d  = kind_q;
    bytes_d = accept ? bytes_q + 1'b1 : bytes_q;
    if (accept) begin
      if (pos_q == '0) begin
        if (in_byte_i == HdrByte) begin
          pos_d = PosBits'(1);
          sum_d = in_byte_i;
        end
      end else if (pos_q == PosBits'(1) && in_kind == KIND_NONE) begin
        if (in_byte_i == HdrByte) begin
          pos_d = PosBits'(1);
          sum_d = in_byte_i;
        end else begin
          pos_d = '0;
          sum_d = '0;
        end
      end else if (!at_last) begin
        if (pos_q == PosBits'(1)) kind_d = in_kind;
        sum_d = sum_q + in_byte_i;
        pos_d = pos_q + 1'b1;
      end else begin
        pos_d = '0;
        sum_d = '0;
      end
    end
    if (cfg_we_i) begin
      pos_d = '0;
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= 1'b1;
      pos_q    <= '0;
      sum_q    <= '0;
      kind_q   <= KIND_GYRO;
      bytes_q  <= '0;
    end else begin
      if (cfg_we_i) format_q <= cfg_wdata_i;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      kind_q  <= kind_d;
      bytes_q <= bytes_d;
    end
  end

  // frame buffer, header at index 0
  always_ff @(posedge clk_i) begin
    if (accept && !at_last) begin
      for (int unsigned j = 0; j < MaxFrameBytes; j++) begin
        if (pos_q == PosBits'(j)) buf_q[j] <= in_byte_i;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/imu_sfp_queue.sv
`default_nettype none

module imu_sfp_queue (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  imu_sfp_pkg::frame_rec_t push_rec_i,
  output logic                    full_o,
  input  wire                     pop_i,
  output logic                    empty_o,
  output imu_sfp_pkg::frame_rec_t pop_rec_o
);
  import imu_sfp_pkg::*;

  frame_rec_t              mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_q, rd_q;
  logic [QueueCntBits-1:0] cnt_q;

  assign full_o    = (cnt_q == QueueCntBits'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign pop_rec_o = mem_q[rd_q];

  function automatic logic [QueuePtrBits-1:0] ptr_inc(input logic [QueuePtrBits-1:0] p);
    return (p == QueuePtrBits'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i) rd_q <= ptr_inc(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_rec_i;
  end

endmodule

`default_nettype wire

### rtl/imu_sfp_back.sv
`default_nettype none

module imu_sfp_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     q_empty_i,
  input  imu_sfp_pkg::frame_rec_t q_rec_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output imu_sfp_pkg::result_t    out_res_o
);
  import imu_sfp_pkg::*;

  count_t  kcnt_q [4];
  count_t  err_q;
  logic    valid_q;
  result_t res_q;

  logic    counted;
  count_t  kcur, knext;

  assign q_pop_o     = !q_empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;
  assign counted     = (q_rec_i.kind != KIND_REG);
  assign kcur        = kcnt_q[q_rec_i.kind[1:0]];
  assign knext       = kcur + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      err_q   <= '0;
      for (int unsigned j = 0; j < 4; j++) kcnt_q[j] <= '0;
    end else begin
      if (q_pop_o) begin
        valid_q <= 1'b1;
        if (!q_rec_i.ok) err_q <= err_q + 1'b1;
        else if (counted) kcnt_q[q_rec_i.kind[1:0]] <= knext;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q.kind       <= q_rec_i.kind;
      res_q.ok         <= q_rec_i.ok;
      res_q.v1         <= q_rec_i.v1;
      res_q.v2         <= q_rec_i.v2;
      res_q.v3         <= q_rec_i.v3;
      res_q.v4         <= q_rec_i.v4;
      res_q.byte_total <= q_rec_i.byte_total;
      res_q.err_total  <= q_rec_i.ok ? err_q : err_q + 1'b1;
      if (!counted) res_q.kind_total <= '0;
      else res_q.kind_total <= q_rec_i.ok ? knext : kcur;
    end
  end

endmodule

`default_nettype wire

### rtl/imu_serial_frame_parser.sv
`default_nettype none

// channel    dir  handshake                      payload
// s_axis     in   s_axis_tvalid_i/tready_o       tdata[7:0] rx_byte
// m_axis     out  m_axis_tvalid_o/tready_i       tuser kind+ok, tdata values+counters
// cfg        in   cfg_we_i                       cfg_wdata_i frame_format
//
// One word per cycle in unless the input stalls; a completed frame leaves no gap on the input side.
// Front parser runs checksum and buffer per word; a finished frame goes into the
// 2-entry frame queue, then into the counter stage's output register (tvalid).
// Input stalls only on the checksum word while the frame queue is full.
// Reset is asynchronous; frame_format resets to six-axis.

module imu_serial_frame_parser (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire          cfg_wdata_i,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [7:0]   s_axis_tdata_i,   // rx_byte
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  output logic [159:0] m_axis_tdata_o,   // value_first, value_second, value_third,
                                         // value_fourth, kind_frame_total,
                                         // checksum_error_total, byte_total
  output logic [3:0]   m_axis_tuser_o    // frame_kind, checksum_ok
);
  import imu_sfp_pkg::*;

  logic       q_full, q_empty, q_push, q_pop;
  frame_rec_t push_rec, pop_rec;
  result_t    res;

  imu_sfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_rec_o     (push_rec)
  );

  imu_sfp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_rec_o  (pop_rec)
  );

  imu_sfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_rec_i     (pop_rec),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tuser_o = {res.ok, res.kind};
  assign m_axis_tdata_o = {res.byte_total[31:0], res.err_total[31:0], res.kind_total[31:0],
                           res.v4, res.v3, res.v2, res.v1};

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("frame queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("frame queue underflow");

  a_bad_sum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !res.ok) |-> (res.v1 == '0 && res.v2 == '0 &&
                                      res.v3 == '0 && res.v4 == '0))
    else $error("values not cleared on checksum mismatch");

  a_reg_total_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res.kind == KIND_REG) |-> (res.kind_total == '0))
    else $error("register frame carries a kind total");

endmodule

`default_nettype wire

### verif/tb_imu_serial_frame_parser.sv
`timescale 1ns / 100ps

module tb_imu_serial_frame_parser;
  import imu_sfp_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PhaseItems   = 225;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned LongHold     = 600;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 20;

  logic         clk_i           = 1'b0;
  logic         rst_ni          = 1'b0;
  logic         cfg_we_i        = 1'b0;
  logic         cfg_wdata_i     = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i  = 8'h00;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [159:0] m_axis_tdata_o;
  logic [3:0]   m_axis_tuser_o;

  imu_serial_frame_parser DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // parser model state
  logic        six_axis;
  logic [3:0]  parse_pos;
  logic [7:0]  frame_buf [MaxFrameBytes];
  logic [7:0]  run_sum;
  count_t      kind_cnt [4];
  count_t      err_cnt;
  count_t      byte_cnt;

  result_t     pending_frames [$];
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  int unsigned words_recv  = 0;
  bit          src_idle    = 1'b1;
  bit          snk_idle    = 1'b1;

  function automatic kind_e decode_type(input logic [7:0] t);
    kind_e k;
    k = KIND_NONE;
    case (t)
      TypeGyro:  k = KIND_GYRO;
      TypeAngle: k = KIND_ANGLE;
      TypeAccel: if (six_axis) k = KIND_ACCEL;
      TypeQuat:  if (six_axis) k = KIND_QUAT;
      TypeReg:   if (six_axis) k = KIND_REG;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Advances the parser model by one byte; returns 1 when a frame completes.
  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    kind_e       k;
    int unsigned flen;
    r = '0;
    flen = six_axis ? Axis6Eff : LegacyEff;
    byte_cnt++;
    if (parse_pos == 0) begin
      if (b == HdrByte) begin
        frame_buf[0] = b;
        run_sum = b;
        parse_pos = 1;
      end
      return 1'b0;
    end
    if (parse_pos == 1 && decode_type(b) == KIND_NONE) begin
      if (b == HdrByte) begin
        frame_buf[0] = b;
        run_sum = b;
      end else begin
        parse_pos = 0;
        run_sum = 8'h00;
      end
      return 1'b0;
    end
    if (int'(parse_pos) + 1 < flen) begin
      frame_buf[parse_pos] = b;
      run_sum += b;
      parse_pos++;
      return 1'b0;
    end
    k = decode_type(frame_buf[1]);
    r.kind = k;
    r.ok = (run_sum == b);
    parse_pos = 0;
    run_sum = 8'h00;
    if (r.ok) begin
      r.v1 = {frame_buf[3], frame_buf[2]};
      if (six_axis) begin
        r.v2 = {frame_buf[5], frame_buf[4]};
        r.v3 = {frame_buf[7], frame_buf[6]};
        if (k == KIND_QUAT) r.v4 = {frame_buf[9], frame_buf[8]};
      end
      if (k != KIND_REG) begin
        kind_cnt[k[1:0]]++;
        r.kind_total = kind_cnt[k[1:0]];
      end
    end else begin
      err_cnt++;
      if (k != KIND_REG) r.kind_total = kind_cnt[k[1:0]];
    end
    r.err_total = err_cnt;
    r.byte_total = byte_cnt;
    return 1'b1;
  endfunction

  task automatic report(input string msg);
    if (err_count < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // drives one word and returns at the edge where it is taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (words_sent % 32 == 0) src_idle = ($urandom_range(0, 3) != 0);
    gap = src_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_and_predict(input logic [7:0] b);
    result_t r;
    send_byte(b);
    if (parse_byte(b, r)) pending_frames.push_back(r);
  endtask

  // waits for an idle block, then writes the frame format
  task automatic set_format(input logic f);
    s_axis_tvalid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= f;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    six_axis  = f;
    parse_pos = 0;
    run_sum   = 8'h00;
  endtask

  function automatic logic [7:0] payload_byte();
    logic [7:0] edges [4];
    edges = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  // one random sequence: mostly well-formed frames, some broken ones and noise
  task automatic send_sequence(inout int unsigned items);
    logic [7:0]  seq [$];
    logic [7:0]  types [5];
    logic [7:0]  sum;
    int unsigned sel;
    int unsigned flen;
    types = '{TypeGyro, TypeAngle, TypeAccel, TypeQuat, TypeReg};
    flen = six_axis ? Axis6Eff : LegacyEff;
    sel = $urandom_range(0, 19);
    if (sel < 15) begin
      seq.push_back(HdrByte);
      if (six_axis || $urandom_range(0, 7) == 0) seq.push_back(types[$urandom_range(0, 4)]);
      else seq.push_back(types[$urandom_range(0, 1)]);
      repeat (flen - 3) seq.push_back(payload_byte());
      sum = 8'h00;
      foreach (seq[i]) sum += seq[i];
      if ($urandom_range(0, 7) == 0) sum ^= 8'($urandom_range(1, 255));
      seq.push_back(sum);
    end else if (sel < 17) begin
      seq.push_back(HdrByte);
      seq.push_back($urandom_range(0, 1) ? HdrByte : 8'($urandom_range(0, 255)));
    end else if (sel < 19) begin
      seq.push_back(HdrByte);
      seq.push_back(types[$urandom_range(0, 4)]);
      repeat ($urandom_range(0, flen - 3)) seq.push_back(payload_byte());
    end else begin
      repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[i]) send_and_predict(seq[i]);
    items += seq.size();
  endtask

  // output side: random stalls, one long hold-off to back up the frame queue
  initial begin
    int unsigned gap;
    bit          long_done;
    result_t     got, want;
    long_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (words_recv % 16 == 0) snk_idle = ($urandom_range(0, 3) != 0);
      gap = snk_idle ? $urandom_range(0, 15) : 0;
      if (!long_done && words_recv == 30) begin
        long_done = 1'b1;
        gap = LongHold;
      end
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      words_recv++;
      got.kind       = kind_e'(m_axis_tuser_o[2:0]);
      got.ok         = m_axis_tuser_o[3];
      got.v1         = m_axis_tdata_o[15:0];
      got.v2         = m_axis_tdata_o[31:16];
      got.v3         = m_axis_tdata_o[47:32];
      got.v4         = m_axis_tdata_o[63:48];
      got.kind_total = m_axis_tdata_o[95:64];
      got.err_total  = m_axis_tdata_o[127:96];
      got.byte_total = m_axis_tdata_o[159:128];
      if (pending_frames.size() == 0) begin
        report($sformatf("unexpected word kind %0d bytes %0d", got.kind, got.byte_total));
      end else begin
        want = pending_frames.pop_front();
        check_field("frame_kind", 32'(got.kind), 32'(want.kind));
        check_field("checksum_ok", 32'(got.ok), 32'(want.ok));
        check_field("value_first", 32'(got.v1), 32'(want.v1));
        check_field("value_second", 32'(got.v2), 32'(want.v2));
        check_field("value_third", 32'(got.v3), 32'(want.v3));
        check_field("value_fourth", 32'(got.v4), 32'(want.v4));
        check_field("kind_frame_total", got.kind_total, want.kind_total);
        check_field("checksum_error_total", got.err_total, want.err_total);
        check_field("byte_total", got.byte_total, want.byte_total);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [7:0]  dir_bytes [26];
    result_t     dir_typed [int];
    result_t     r;
    logic        fmt_plan [NumPhases];
    int unsigned items;

    // noise, header-header, bad type, quaternion frame with extreme values,
    // then a register frame with a bad checksum
    dir_bytes = '{8'h00, 8'h5A, 8'h5A, 8'h13, 8'h5A, 8'hDD, 8'hFF, 8'h7F, 8'h00,
                  8'h80, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h34,
                  8'h5A, 8'hEE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h49};
    dir_typed[14] = '{KIND_QUAT, 1'b1, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                      32'd1, 32'd0, 32'd15};
    dir_typed[25] = '{KIND_REG, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      32'd0, 32'd1, 32'd26};
    fmt_plan = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    six_axis  = 1'b1;
    parse_pos = 0;
    run_sum   = 8'h00;
    err_cnt   = '0;
    byte_cnt  = '0;
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
    foreach (kind_cnt[i]) kind_cnt[i] = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_bytes[i]) begin
      send_byte(dir_bytes[i]);
      if (parse_byte(dir_bytes[i], r)) begin
        pending_frames.push_back(dir_typed.exists(i) ? dir_typed[i] : r);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      set_format(fmt_plan[p]);
      items = 0;
      while (items < PhaseItems) send_sequence(items);
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
